/* sv/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and the divide-by-nine helper for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int CFG_W        = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_FLUSH = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} s1_ctrl_t;

	// floor(sum / 9) for sums up to 9 * 255, by reciprocal multiplication
	localparam int               MEAN_SHIFT = 15;
	localparam logic [11:0]      MEAN_MULT  = 12'd3641;

	function automatic logic [7:0] mean9(input logic [11:0] sum);
		logic [23:0] prod;
		prod = 24'(sum) * 24'(MEAN_MULT);
		return prod[MEAN_SHIFT+7:MEAN_SHIFT];
	endfunction

endpackage

/* sv/bb3_ram.sv */
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/box_blur_3x3.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 mean filter over 24-bit blue/green/red pixels in raster order.
// ----------------------------------------------------------------------------
// One transaction per clock in and out while the output is not stalled. An accepted
// pixel reads the two stored rows for its column from one line memory (one read
// and one write port, read registered), then, when its stage advances, shifts the
// 3x3 window, writes the column back and forms the result, which is held in the
// output register. The output stream trails the input by one row plus one
// pixel; after the last pixel of a frame, width+1 flush transactions drain it
// and the final result carries frame_end. Interior pixels get floor(sum/9) per
// channel, border pixels pass unchanged. Writing either register restarts the
// frame.
module box_blur_3x3 #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [7:0]                blue_in,
	input  logic [7:0]                green_in,
	input  logic [7:0]                red_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                blue_out,
	output logic [7:0]                green_out,
	output logic [7:0]                red_out,
	output logic                      frame_end
);
	import bb3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $bits(pixel_t);
	localparam int LW = 2 * PW;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q;
	logic [WW-1:0]           drain_q;
	logic                    full_q;

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	logic          is_flush;
	logic          ignore_a;
	logic          last_a;
	logic          accept;
	logic          shift_a;
	logic [CW-1:0] col_a;
	pixel_t        px_a;
	s1_ctrl_t      ctrl_a;
	logic          col_wrap;
	logic          row_wrap;

	logic          valid_s1;
	pixel_t        px_s1;
	logic [CW-1:0] col_s1;
	s1_ctrl_t      ctrl_s1;
	logic          fwd_hit_s1;
	logic [LW-1:0] fwd_data_s1;
	logic          s1_adv;

	logic [LW-1:0] ram_rdata;
	logic [LW-1:0] rd;
	pixel_t        rd_up;
	pixel_t        rd_mid;

	pixel_t        win_q [3][3];
	pixel_t        win_n [3][3];
	pixel_t        col_new [3];
	logic [11:0]   sum_b;
	logic [11:0]   sum_g;
	logic [11:0]   sum_r;
	pixel_t        res;

	logic          out_valid_q;
	pixel_t        out_px_q;
	logic          out_last_q;

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
	end

	always_comb begin
		is_flush = (kind == KIND_FLUSH);
		ignore_a = is_flush ? !full_q : full_q;
		last_a   = (drain_q >= eff_w);
		col_wrap = ((WW'(col_q) + WW'(1)) >= eff_w);
		row_wrap = ((HW'(row_q) + HW'(1)) >= eff_h);
		if (is_flush) begin
			col_a         = last_a ? '0 : drain_q[CW-1:0];
			px_a          = '0;
			ctrl_a.emit   = last_a || (drain_q != '0) || (eff_h >= HW'(2));
			ctrl_a.interior = 1'b0;
			ctrl_a.last   = last_a;
		end else begin
			col_a         = col_q;
			px_a          = {red_in, green_in, blue_in};
			ctrl_a.emit   = ((col_q != '0) && (row_q != '0)) ||
				((col_q == '0) && (row_q >= RW'(2)));
			ctrl_a.interior = (row_q >= RW'(2)) && (col_q >= CW'(2));
			ctrl_a.last   = 1'b0;
		end
	end

	assign s1_adv   = valid_s1 && (!ctrl_s1.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;
	assign shift_a  = accept && !ignore_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
			full_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
			endcase
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
			full_q  <= 1'b0;
		end else if (shift_a) begin
			if (is_flush) begin
				if (last_a) begin
					drain_q <= '0;
					full_q  <= 1'b0;
				end else begin
					drain_q <= drain_q + WW'(1);
				end
			end else if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					full_q <= 1'b1;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			ctrl_s1    <= '0;
			fwd_hit_s1 <= 1'b0;
		end else if (shift_a) begin
			valid_s1   <= 1'b1;
			ctrl_s1    <= ctrl_a;
			fwd_hit_s1 <= s1_adv && (col_s1 == col_a);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_a) begin
			px_s1       <= px_a;
			col_s1      <= col_a;
			fwd_data_s1 <= {rd_mid, px_s1};
		end
	end

	bb3_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata ({rd_mid, px_s1}),
		.re    (shift_a),
		.raddr (col_a),
		.rdata (ram_rdata)
	);

	assign rd     = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign rd_up  = rd[LW-1:PW];
	assign rd_mid = rd[PW-1:0];

	always_comb begin
		col_new[0] = rd_up;
		col_new[1] = rd_mid;
		col_new[2] = px_s1;
		for (int k = 0; k < 3; k++) begin
			win_n[k][0] = win_q[k][1];
			win_n[k][1] = win_q[k][2];
			win_n[k][2] = col_new[k];
		end
		sum_b = '0;
		sum_g = '0;
		sum_r = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sum_b = sum_b + 12'(win_n[i][j].blue);
				sum_g = sum_g + 12'(win_n[i][j].green);
				sum_r = sum_r + 12'(win_n[i][j].red);
			end
		end
		if (ctrl_s1.interior) begin
			res = {mean9(sum_r), mean9(sum_g), mean9(sum_b)};
		end else begin
			res = win_n[1][1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s1_adv) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctrl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctrl_s1.emit) begin
			out_px_q   <= res;
			out_last_q <= ctrl_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign blue_out  = out_px_q.blue;
	assign green_out = out_px_q.green;
	assign red_out   = out_px_q.red;
	assign frame_end = out_last_q;

endmodule

/* test/box_blur_3x3_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_test
// Self-checking testbench for the streaming 3x3 box blur.
// A short directed run covers clamped sizes, flush and pixel transactions that
// are ignored, and a frame restart. Random frames of mostly small sizes follow,
// plus two partial frames at the saturated width and height. A line-buffer
// predictor models every accepted transaction. Output transactions are compared
// field by field against the oldest predicted pixel. The sender idles in bursts
// and the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module box_blur_3x3_test;
	import bb3_pkg::*;

	localparam int MAX_W        = DEF_MAX_WIDTH;
	localparam int MAX_H        = DEF_MAX_HEIGHT;
	localparam int RANDOM_ITEMS = 1950;
	localparam int LIMIT_NS     = 8_000_000;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
	} blur_result_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_SPARSE,
		RDY_PATTERN
	} ready_mode_t;

	class blur_tracker;
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		pixel_t       upper_row [MAX_W];
		pixel_t       middle_row[MAX_W];
		pixel_t       win[3][3];
		int unsigned  col;
		int unsigned  row;
		int unsigned  drained;
		bit           frame_complete;
		blur_result_t pending_pixels[$];
		int           errors;
		int           checked;
		int           frames_done;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			errors      = 0;
			checked     = 0;
			frames_done = 0;
			restart();
		endfunction

		function void restart();
			col            = 0;
			row            = 0;
			drained        = 0;
			frame_complete = 1'b0;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_H) return MAX_H;
			return height_reg;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = value[WIDTH_REG_W-1:0];
			end else begin
				height_reg = value[HEIGHT_REG_W-1:0];
			end
			restart();
		endfunction

		function void shift_window(int unsigned c, pixel_t px);
			pixel_t col_new[3];
			col_new[0] = upper_row[c];
			col_new[1] = middle_row[c];
			col_new[2] = px;
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
				win[k][2] = col_new[k];
			end
			upper_row[c]  = middle_row[c];
			middle_row[c] = px;
		endfunction

		// input at (vr, vc) yields the pixel one row and one column back
		function void filtered_pixel(int unsigned vr, int unsigned vc, int unsigned w,
				int unsigned h, bit last_px);
			int unsigned  pr;
			int unsigned  pc;
			int unsigned  sum_b;
			int unsigned  sum_g;
			int unsigned  sum_r;
			blur_result_t res;
			if (vc >= 1) begin
				if (vr < 1) return;
				pr = vr - 1;
				pc = vc - 1;
			end else begin
				if (vr < 2) return;
				pr = vr - 2;
				pc = w - 1;
			end
			if (pr >= 1 && pr + 2 <= h && pc >= 1 && pc + 2 <= w) begin
				sum_b = 0;
				sum_g = 0;
				sum_r = 0;
				foreach (win[i, j]) begin
					sum_b += win[i][j].blue;
					sum_g += win[i][j].green;
					sum_r += win[i][j].red;
				end
				res.blue  = 8'(sum_b / 9);
				res.green = 8'(sum_g / 9);
				res.red   = 8'(sum_r / 9);
			end else begin
				res.blue  = win[1][1].blue;
				res.green = win[1][1].green;
				res.red   = win[1][1].red;
			end
			res.last = last_px;
			pending_pixels.insert(pending_pixels.size(), res);
		endfunction

		function void accept_input(kind_t k, pixel_t px);
			int unsigned w;
			int unsigned h;
			int unsigned d;
			bit          fin;
			w = eff_width();
			h = eff_height();
			if (k == KIND_PIXEL) begin
				if (frame_complete) return;
				shift_window(col % MAX_W, px);
				filtered_pixel(row, col, w, h, 1'b0);
				col++;
				if (col >= w) begin
					col = 0;
					row++;
					if (row >= h) begin
						row            = 0;
						frame_complete = 1'b1;
					end
				end
			end else begin
				if (!frame_complete) return;
				d   = drained;
				fin = (d >= w);
				shift_window(fin ? 0 : d, '0);
				filtered_pixel(fin ? h + 1 : h, fin ? 0 : d, w, h, fin);
				if (fin) begin
					restart();
					frames_done++;
				end else begin
					drained = d + 1;
				end
			end
		endfunction

		function void compare_output(logic [7:0] b, logic [7:0] g, logic [7:0] r,
				logic fe);
			blur_result_t e;
			if (pending_pixels.size() == 0) begin
				$error("output transaction with no pixel expected");
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			checked++;
			if (b !== e.blue) begin
				$error("blue_out: expected %0d, actual %0d", e.blue, b);
				errors++;
			end
			if (g !== e.green) begin
				$error("green_out: expected %0d, actual %0d", e.green, g);
				errors++;
			end
			if (r !== e.red) begin
				$error("red_out: expected %0d, actual %0d", e.red, r);
				errors++;
			end
			if (fe !== e.last) begin
				$error("frame_end: expected %0d, actual %0d", e.last, fe);
				errors++;
			end
		endfunction

		function int backlog();
			return pending_pixels.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic             kind;
	logic [7:0]       blue_in;
	logic [7:0]       green_in;
	logic [7:0]       red_in;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       blue_out;
	logic [7:0]       green_out;
	logic [7:0]       red_out;
	logic             frame_end;

	blur_tracker tracker;
	int          burst_left  = 0;
	int          accepted    = 0;
	int          reg_writes  = 0;
	ready_mode_t ready_mode  = RDY_ALWAYS;
	int          mode_left   = 0;
	logic [7:0]  ready_mask  = 8'hff;
	logic [2:0]  ready_phase = '0;

	box_blur_3x3 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out),
		.frame_end (frame_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				tracker.compare_output(blue_out, green_out, red_out, frame_end);
			end
			if (in_valid && in_ready) begin
				tracker.accept_input(kind_t'(kind), {red_in, green_in, blue_in});
				accepted++;
			end
		end
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode  = ready_mode_t'($urandom_range(0, 3));
			mode_left   = $urandom_range(20, 300);
			ready_mask  = 8'($urandom) | 8'h01;
		end
		mode_left--;
		ready_phase++;
		case (ready_mode)
			RDY_ALWAYS:  out_ready = 1'b1;
			RDY_HALF:    out_ready = 1'($urandom_range(0, 1));
			RDY_SPARSE:  out_ready = ($urandom_range(0, 4) == 0);
			default:     out_ready = ready_mask[ready_phase];
		endcase
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p = 24'($urandom);
		if ($urandom_range(0, 7) == 0) p.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if ($urandom_range(0, 7) == 0) p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
		if ($urandom_range(0, 7) == 0) p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
		return p;
	endfunction

	// called and returning at a falling edge
	task automatic send_item(kind_t k, pixel_t px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 400)
				: $urandom_range(1, 16);
		end
		in_valid = 1'b1;
		kind     = k;
		blue_in  = px.blue;
		green_in = px.green;
		red_in   = px.red;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic hold_until_drained();
		in_valid   = 1'b0;
		burst_left = 0;
		while (tracker.backlog() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		tracker.write_reg(idx, value);
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic cfg_idle();
		cfg_we = 1'b0;
	endtask

	initial begin
		int          w_val;
		int          h_val;
		int unsigned w_eff;
		int unsigned h_eff;
		int          total;
		int          abort_at;
		int          pause_at;
		int          pick;
		int          frame_no;
		int          sent_items;
		int          waited;
		int          fails;
		bit          large_frame;
		bit          need_restart;
		bit          force_both;
		pixel_t      px;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		kind      = KIND_PIXEL;
		blue_in   = '0;
		green_in  = '0;
		red_in    = '0;
		tracker   = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero sizes clamp to 1x1; early flush and late pixel are dropped
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '0);
		cfg_idle();
		send_item(KIND_FLUSH, 24'h123456);
		send_item(KIND_PIXEL, 24'hffffff);
		send_item(KIND_PIXEL, 24'h000000);
		send_item(KIND_FLUSH, 24'h000000);
		send_item(KIND_FLUSH, 24'hffffff);
		hold_until_drained();

		// smallest frame with an interior pixel
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		cfg_idle();
		for (int i = 0; i < 9; i++) begin
			px.blue  = 8'hff;
			px.green = (i == 4) ? 8'hff : 8'h00;
			px.red   = 8'(i * 31);
			send_item(KIND_PIXEL, px);
		end
		repeat (4) send_item(KIND_FLUSH, 24'hffffff);
		hold_until_drained();

		// abandon a frame part way; the next register write restarts it
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		cfg_idle();
		repeat (4) send_item(KIND_PIXEL, rand_pixel());
		hold_until_drained();
		need_restart = 1'b1;
		force_both   = 1'b0;

		frame_no   = 0;
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS || frame_no <= 5) begin
			large_frame = (frame_no == 2 || frame_no == 5);
			if (need_restart || large_frame || force_both || $urandom_range(0, 9) < 7) begin
				hold_until_drained();
				if (frame_no == 2) begin
					w_val = 2047;
					h_val = 3;
				end else if (frame_no == 5) begin
					w_val = 1;
					h_val = 8191;
				end else begin
					pick  = $urandom_range(0, 99);
					w_val = (pick < 10) ? 0 : (pick < 60) ? $urandom_range(1, 6)
						: (pick < 85) ? $urandom_range(7, 16) : $urandom_range(17, 48);
					pick  = $urandom_range(0, 99);
					h_val = (pick < 8) ? 0 : (pick < 60) ? $urandom_range(1, 5)
						: (pick < 90) ? $urandom_range(6, 12) : $urandom_range(13, 24);
				end
				pick = (large_frame || force_both) ? $urandom_range(0, 1) : $urandom_range(0, 3);
				case (pick)
					0: begin
						write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'(w_val)});
						write_reg(REG_FRAME_HEIGHT, 13'(h_val));
					end
					1: begin
						write_reg(REG_FRAME_HEIGHT, 13'(h_val));
						write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'(w_val)});
					end
					2: write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'(w_val)});
					default: write_reg(REG_FRAME_HEIGHT, 13'(h_val));
				endcase
				cfg_idle();
				need_restart = 1'b0;
				force_both   = large_frame;
			end

			w_eff    = tracker.eff_width();
			h_eff    = tracker.eff_height();
			total    = w_eff * h_eff + w_eff + 1;
			// cut saturated frames short, past the first row wrap
			abort_at = large_frame ? ((frame_no == 2) ? 1100 : 300)
				: ($urandom_range(0, 99) < 8) ? $urandom_range(0, total - 1) : -1;
			pause_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, total - 1) : -1;
			for (int i = 0; i < total; i++) begin
				if (i == abort_at) begin
					need_restart = 1'b1;
					break;
				end
				if (i == pause_at) hold_until_drained();
				if (i < w_eff * h_eff) begin
					if ($urandom_range(0, 49) == 0) send_item(KIND_FLUSH, rand_pixel());
					send_item(KIND_PIXEL, rand_pixel());
				end else begin
					if (i == w_eff * h_eff && $urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 3)) send_item(KIND_PIXEL, rand_pixel());
					end
					send_item(KIND_FLUSH, rand_pixel());
				end
				sent_items++;
			end
			frame_no++;
		end

		in_valid   = 1'b0;
		burst_left = 0;
		waited     = 0;
		while (tracker.backlog() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (tracker.backlog() != 0) begin
			$error("%0d expected pixels never came out", tracker.backlog());
		end
		fails = tracker.errors + tracker.backlog();

		$display("Summary: %0d input transactions, %0d output pixels checked, %0d frames",
			accepted, tracker.checked, tracker.frames_done);
		$display("Summary: %0d register writes, sizes from 1x1, rows up to 1024 wide",
			reg_writes);
		if (fails == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/bb3_pkg.sv
sv/bb3_ram.sv
sv/box_blur_3x3.sv
test/box_blur_3x3_test.sv
